/* hdl/tdmcc_pkg.sv */
// shared types, constants and microcode program for the 2-d min coin change block
package tdmcc_pkg;

  // fixed field widths
  localparam int unsigned COIN_W = 9;
  localparam int unsigned TGT_W  = 9;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned STEP_W = 4;

  // table entry codes
  localparam logic [CNT_W-1:0] UNREACHED = 10'd1023;
  localparam logic [CNT_W-1:0] TOP_COUNT = 10'd1022;

  // datapath actions, one per microcode step
  typedef enum logic [3:0] {
    ACT_IDLE,
    ACT_INIT,
    ACT_ROW,
    ACT_CELL,
    ACT_RDCOIN,
    ACT_RDDP,
    ACT_UPD,
    ACT_WRITE,
    ACT_NEXTA,
    ACT_DONE
  } act_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_GO,
    C_TGT_BAD,
    C_SKIP,
    C_MORE_COINS,
    C_MORE_B,
    C_MORE_A
  } cond_t;

  // one control word
  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // status flags from datapath to sequencer
  typedef struct packed {
    logic go;
    logic tgt_bad;
    logic skip;
    logic more_coins;
    logic more_b;
    logic more_a;
  } flags_t;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ROW    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CELL   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RDCOIN = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RDDP   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_UPD    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WRITE  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_NEXTA  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DONE   = 4'd9;

  // control store
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      STEP_IDLE:   w = '{ACT_IDLE,   C_NOT_GO,     STEP_IDLE};
      STEP_INIT:   w = '{ACT_INIT,   C_TGT_BAD,    STEP_DONE};
      STEP_ROW:    w = '{ACT_ROW,    C_NONE,       STEP_IDLE};
      STEP_CELL:   w = '{ACT_CELL,   C_SKIP,       STEP_WRITE};
      STEP_RDCOIN: w = '{ACT_RDCOIN, C_NONE,       STEP_IDLE};
      STEP_RDDP:   w = '{ACT_RDDP,   C_NONE,       STEP_IDLE};
      STEP_UPD:    w = '{ACT_UPD,    C_MORE_COINS, STEP_RDCOIN};
      STEP_WRITE:  w = '{ACT_WRITE,  C_MORE_B,     STEP_CELL};
      STEP_NEXTA:  w = '{ACT_NEXTA,  C_MORE_A,     STEP_ROW};
      STEP_DONE:   w = '{ACT_DONE,   C_ALWAYS,     STEP_IDLE};
      default:     w = '{ACT_IDLE,   C_ALWAYS,     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/tdmcc_useq.sv */
// microcode sequencer: step counter, control store and conditional jumps
module tdmcc_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  tdmcc_pkg::flags_t   flags,
  output tdmcc_pkg::act_t     act
);

  logic [tdmcc_pkg::STEP_W-1:0] step_r;
  logic [tdmcc_pkg::STEP_W-1:0] step_nxt;
  tdmcc_pkg::uword_t            word;
  logic                         taken;

  // fetch and jump decision
  always_comb begin
    word = tdmcc_pkg::ucode_rom(step_r);
    unique case (word.cond)
      tdmcc_pkg::C_NONE:       taken = 1'b0;
      tdmcc_pkg::C_ALWAYS:     taken = 1'b1;
      tdmcc_pkg::C_NOT_GO:     taken = !flags.go;
      tdmcc_pkg::C_TGT_BAD:    taken = flags.tgt_bad;
      tdmcc_pkg::C_SKIP:       taken = flags.skip;
      tdmcc_pkg::C_MORE_COINS: taken = flags.more_coins;
      tdmcc_pkg::C_MORE_B:     taken = flags.more_b;
      tdmcc_pkg::C_MORE_A:     taken = flags.more_a;
      default:                 taken = 1'b1;
    endcase
    step_nxt = taken ? word.target : step_r + tdmcc_pkg::STEP_W'(1);
    act      = word.act;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tdmcc_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* hdl/two_dim_min_coin_change.sv */
// top level: coin store, dp table and datapath driven by the microcode sequencer
//
// Coin beats are taken one per cycle while busy is low; a coin of (0,0) is
// ignored and coins past MAX_COINS are dropped. A beat with in_last_coin set
// stores its coin and starts the solve, which holds busy high until the single
// result is strobed on out_valid for one cycle; the receiver cannot stall it.
// The solve walks every cell (a,b) of a square of side S+1 (S = target) in
// order and, per cell, every stored coin through the single read port of the
// coin store and then of the dp memory; a target above MAX_TARGET skips the
// walk and yields a result that is not possible. Neither memory is cleared
// after reset: every table entry is written before it is read.
module two_dim_min_coin_change #(
  parameter int unsigned MAX_TARGET = 511,
  parameter int unsigned MAX_COINS  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tdmcc_pkg::COIN_W-1:0]      in_coin_first,
  input  logic [tdmcc_pkg::COIN_W-1:0]      in_coin_second,
  input  logic                              in_last_coin,
  output logic                              out_valid,
  output logic [tdmcc_pkg::CNT_W-1:0]       out_min_coins,
  output logic                              out_possible,
  input  logic                              cfg_we,
  input  logic [tdmcc_pkg::TGT_W-1:0]       cfg_wdata
);

  localparam int unsigned AW   = (MAX_TARGET > 1) ? $clog2(MAX_TARGET + 1) : 1;
  localparam int unsigned CMW  = (AW > tdmcc_pkg::COIN_W) ? AW : tdmcc_pkg::COIN_W;
  localparam int unsigned SQW  = 2 * CMW + 1;
  localparam int unsigned CW   = $clog2(MAX_COINS + 1);
  localparam int unsigned CIW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int unsigned DPD  = 1 << (2 * AW);
  localparam int unsigned CNW  = tdmcc_pkg::CNT_W;

  tdmcc_pkg::act_t   act;
  tdmcc_pkg::flags_t flags;

  // memories
  logic [2*tdmcc_pkg::COIN_W-1:0] coin_mem [0:MAX_COINS-1];
  logic [CNW-1:0]                 dp_mem   [0:DPD-1];
  logic [2*tdmcc_pkg::COIN_W-1:0] coin_q_r;
  logic [CNW-1:0]                 dp_q_r;

  // registers
  logic [tdmcc_pkg::TGT_W-1:0] target_r;
  logic [CW-1:0]  coin_cnt_r, coin_cnt_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [AW-1:0]  a_r, a_nxt;
  logic [AW-1:0]  b_r, b_nxt;
  logic [SQW-1:0] asq_r, asq_nxt;
  logic [SQW-1:0] bsq_r, bsq_nxt;
  logic [SQW-1:0] ssq_r, ssq_nxt;
  logic [CNW-1:0] v_r, v_nxt;
  logic [CNW-1:0] best_r, best_nxt;
  logic           fit_r, fit_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CNW-1:0] out_min_r, out_min_nxt;
  logic           out_poss_r, out_poss_nxt;

  // combinational helpers
  logic           accept;
  logic           coin_nz;
  logic           coin_wr;
  logic [CMW-1:0] ca_ext, cb_ext, a_ext, b_ext, s_ext;
  logic [CMW-1:0] da, db;
  logic [2*AW-1:0] rd_addr;
  logic           fits;
  logic [CNW-1:0] cand;
  logic           on_circle;

  tdmcc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  assign busy   = (act != tdmcc_pkg::ACT_IDLE);
  assign accept = start && !busy;

  // coin beat store decision
  assign coin_nz = (in_coin_first != '0) || (in_coin_second != '0);
  assign coin_wr = accept && coin_nz && (coin_cnt_r < CW'(MAX_COINS));

  // coin fit check and predecessor address
  assign ca_ext    = CMW'(coin_q_r[tdmcc_pkg::COIN_W-1:0]);
  assign cb_ext    = CMW'(coin_q_r[2*tdmcc_pkg::COIN_W-1:tdmcc_pkg::COIN_W]);
  assign a_ext     = CMW'(a_r);
  assign b_ext     = CMW'(b_r);
  assign s_ext     = CMW'(target_r);
  assign fits      = (ca_ext <= a_ext) && (cb_ext <= b_ext);
  assign da        = a_ext - ca_ext;
  assign db        = b_ext - cb_ext;
  assign rd_addr   = {da[AW-1:0], db[AW-1:0]};
  assign cand      = (dp_q_r >= tdmcc_pkg::TOP_COUNT) ? tdmcc_pkg::TOP_COUNT
                                                      : dp_q_r + CNW'(1);
  assign on_circle = (asq_r + bsq_r) == ssq_r;

  // flags to the sequencer
  always_comb begin
    flags.go         = accept && in_last_coin;
    flags.tgt_bad    = s_ext > CMW'(MAX_TARGET);
    flags.skip       = ((a_r == '0) && (b_r == '0)) || (coin_cnt_r == '0);
    flags.more_coins = k_r < coin_cnt_r;
    flags.more_b     = b_ext != s_ext;
    flags.more_a     = a_ext != s_ext;
  end

  // datapath next state per action
  always_comb begin
    coin_cnt_nxt  = coin_cnt_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    asq_nxt       = asq_r;
    bsq_nxt       = bsq_r;
    ssq_nxt       = ssq_r;
    v_nxt         = v_r;
    best_nxt      = best_r;
    fit_nxt       = fit_r;
    out_valid_nxt = 1'b0;
    out_min_nxt   = out_min_r;
    out_poss_nxt  = out_poss_r;
    unique case (act)
      tdmcc_pkg::ACT_IDLE: begin
        if (coin_wr) begin
          coin_cnt_nxt = coin_cnt_r + CW'(1);
        end
      end
      tdmcc_pkg::ACT_INIT: begin
        ssq_nxt  = SQW'(target_r) * SQW'(target_r);
        a_nxt    = '0;
        asq_nxt  = '0;
        best_nxt = tdmcc_pkg::UNREACHED;
      end
      tdmcc_pkg::ACT_ROW: begin
        b_nxt   = '0;
        bsq_nxt = '0;
      end
      tdmcc_pkg::ACT_CELL: begin
        k_nxt = '0;
        v_nxt = ((a_r == '0) && (b_r == '0)) ? '0 : tdmcc_pkg::UNREACHED;
      end
      tdmcc_pkg::ACT_RDCOIN: begin
        // coin read is in flight
      end
      tdmcc_pkg::ACT_RDDP: begin
        fit_nxt = fits;
        k_nxt   = k_r + CW'(1);
      end
      tdmcc_pkg::ACT_UPD: begin
        if (fit_r && (dp_q_r != tdmcc_pkg::UNREACHED) && (cand < v_r)) begin
          v_nxt = cand;
        end
      end
      tdmcc_pkg::ACT_WRITE: begin
        if (on_circle && (v_r < best_r)) begin
          best_nxt = v_r;
        end
        b_nxt   = b_r + AW'(1);
        bsq_nxt = bsq_r + SQW'({b_r, 1'b1});
      end
      tdmcc_pkg::ACT_NEXTA: begin
        a_nxt   = a_r + AW'(1);
        asq_nxt = asq_r + SQW'({a_r, 1'b1});
      end
      tdmcc_pkg::ACT_DONE: begin
        coin_cnt_nxt  = '0;
        out_valid_nxt = 1'b1;
        out_poss_nxt  = (best_r != tdmcc_pkg::UNREACHED);
        out_min_nxt   = (best_r != tdmcc_pkg::UNREACHED) ? best_r : '0;
      end
      default: begin
        coin_cnt_nxt = coin_cnt_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      coin_cnt_r  <= '0;
      best_r      <= tdmcc_pkg::UNREACHED;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      coin_cnt_r  <= coin_cnt_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    asq_r      <= asq_nxt;
    bsq_r      <= bsq_nxt;
    ssq_r      <= ssq_nxt;
    v_r        <= v_nxt;
    fit_r      <= fit_nxt;
    out_min_r  <= out_min_nxt;
    out_poss_r <= out_poss_nxt;
  end

  // coin store
  always_ff @(posedge clk) begin
    if (coin_wr) begin
      coin_mem[coin_cnt_r[CIW-1:0]] <= {in_coin_second, in_coin_first};
    end
    coin_q_r <= coin_mem[k_r[CIW-1:0]];
  end

  // dp table
  always_ff @(posedge clk) begin
    if (act == tdmcc_pkg::ACT_WRITE) begin
      dp_mem[{a_r, b_r}] <= v_r;
    end
    dp_q_r <= dp_mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_min_coins = out_min_r;
  assign out_possible  = out_poss_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("busy while result is shown");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    coin_cnt_r <= CW'(MAX_COINS))
    else $error("coin count above store depth");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (act == tdmcc_pkg::ACT_UPD) |-> (k_r <= coin_cnt_r))
    else $error("coin index ran past coin count");

endmodule
